// ===== hw/rtl/ccz_pkg.sv =====
// ccz_pkg: shared types and constants of the center crop 2x zoom unit
// used by ccz_front, ccz_queue, ccz_back and center_crop_zoom_2x_unit
`timescale 1ns / 1ps
`default_nettype none

package ccz_pkg;

  localparam int CFG_BITS       = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int MIN_SIZE       = 4;
  localparam int MARK_ROWS      = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 10'd512;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 10'd512;

  typedef enum logic [2:0] {
    SEQ_WAIT   = 3'b001,
    SEQ_FIRST  = 3'b010,
    SEQ_REPEAT = 3'b100
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccz_queue.sv =====
// ccz_queue: small fifo of store commands between front and back
// depends on ccz_pkg for the depth
`timescale 1ns / 1ps
`default_nettype none

module ccz_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic [WIDTH-1:0]      pop_data
);
  import ccz_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full     = (count == (PW+1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !(push && !pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !pop)
    else $error("queue underflow");

endmodule

`default_nettype wire

// ===== hw/rtl/ccz_front.sv =====
// ccz_front: config registers, input counters, window test and output sequencer
// turns each input beat into one store write/read command; depends on ccz_pkg
`timescale 1ns / 1ps
`default_nettype none

module ccz_front #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8,
  parameter int AW         = 16,
  parameter int EW         = 3 + 2 * 16 + 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [ccz_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [ccz_pkg::CFG_BITS-1:0]          cfg_data,
  input  wire logic                                  accept,
  input  wire logic                                  clear_n,
  input  wire logic                                  frame_start,
  input  wire logic                                  pixel_valid,
  input  wire logic [PIXEL_BITS-1:0]                 pixel_value,
  output logic [EW-1:0]                              cmd
);
  import ccz_pkg::*;

  localparam int HALF_W = MAX_WIDTH / 2;
  localparam int HALF_H = MAX_HEIGHT / 2;
  localparam int CB     = $clog2(HALF_W);
  localparam int RB     = $clog2(HALF_H);
  localparam int ICW    = $clog2(MAX_WIDTH);
  localparam int IRW    = $clog2(MAX_HEIGHT);
  localparam int WW     = ICW + 1;
  localparam int HW     = IRW + 1;
  localparam int CMPW_W = (WW > CFG_BITS) ? WW : CFG_BITS;
  localparam int CMPW_H = (HW > CFG_BITS) ? HW : CFG_BITS;

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;

  logic           armed;
  logic [ICW-1:0] in_column;
  logic [IRW-1:0] in_row;
  logic [CB-1:0]  out_column;
  logic [RB-1:0]  out_row;
  logic           second_pass;
  seq_state_t     state;
  logic           held_mark;

  logic           armed_next;
  logic [ICW-1:0] in_column_next;
  logic [IRW-1:0] in_row_next;
  logic [CB-1:0]  out_column_next;
  logic [RB-1:0]  out_row_next;
  logic           second_pass_next;
  seq_state_t     state_next;
  logic           held_mark_next;

  logic [CMPW_W-1:0] w_clamp;
  logic [CMPW_H-1:0] h_clamp;
  logic [WW-1:0]     w;
  logic [HW-1:0]     h;
  logic [WW-1:0]     qw;
  logic [HW-1:0]     qh;
  logic [WW-1:0]     col_ext;
  logic [HW-1:0]     row_ext;
  logic [WW-1:0]     col_diff;
  logic [HW-1:0]     row_diff;
  logic              in_window;
  seq_state_t        seq_cur;

  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective size: clamp to 4..max, round down to a multiple of four
  always_comb begin
    w_clamp = CMPW_W'(frame_width);
    if (w_clamp < CMPW_W'(MIN_SIZE)) begin
      w_clamp = CMPW_W'(MIN_SIZE);
    end
    if (w_clamp > CMPW_W'(MAX_WIDTH)) begin
      w_clamp = CMPW_W'(MAX_WIDTH);
    end
    h_clamp = CMPW_H'(frame_height);
    if (h_clamp < CMPW_H'(MIN_SIZE)) begin
      h_clamp = CMPW_H'(MIN_SIZE);
    end
    if (h_clamp > CMPW_H'(MAX_HEIGHT)) begin
      h_clamp = CMPW_H'(MAX_HEIGHT);
    end
  end

  assign w        = WW'(w_clamp) & ~WW'(3);
  assign h        = HW'(h_clamp) & ~HW'(3);
  assign qw       = w >> 2;
  assign qh       = h >> 2;
  assign col_ext  = WW'(in_column);
  assign row_ext  = HW'(in_row);
  assign col_diff = col_ext - qw;
  assign row_diff = row_ext - qh;
  assign in_window = (row_ext >= qh) && (row_ext < (qh + (qh << 1)))
                  && (col_ext >= qw) && (col_ext < (qw + (qw << 1)));
  assign wr_addr  = {row_diff[RB-1:0], col_diff[CB-1:0]};
  assign rd_addr  = {out_row, out_column};

  always_comb begin
    armed_next       = armed;
    in_column_next   = in_column;
    in_row_next      = in_row;
    out_column_next  = out_column;
    out_row_next     = out_row;
    second_pass_next = second_pass;
    state_next       = state;
    held_mark_next   = held_mark;
    seq_cur          = state;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    if (!clear_n) begin
      armed_next       = 1'b0;
      in_column_next   = '0;
      in_row_next      = '0;
      out_column_next  = '0;
      out_row_next     = '0;
      second_pass_next = 1'b0;
      state_next       = SEQ_WAIT;
      held_mark_next   = 1'b0;
    end else begin
      armed_next = armed | frame_start;
      if (pixel_valid && armed_next) begin
        if (in_window) begin
          wr_en = 1'b1;
          if (state == SEQ_WAIT) begin
            seq_cur = SEQ_FIRST;
          end
        end
        if (col_ext < w - 1'b1) begin
          in_column_next = in_column + 1'b1;
        end else begin
          in_column_next = '0;
          if (row_ext < h - 1'b1) begin
            in_row_next = in_row + 1'b1;
          end else begin
            in_row_next = '0;
            armed_next  = 1'b0;
          end
        end
      end
      unique case (seq_cur)
        SEQ_FIRST: begin
          rd_en          = 1'b1;
          held_mark_next = (out_row < RB'(MARK_ROWS));
          state_next     = SEQ_REPEAT;
        end
        SEQ_REPEAT: begin
          rd_en          = 1'b1;
          held_mark_next = (out_row < RB'(MARK_ROWS));
          if (WW'(out_column) < (w >> 1) - 1'b1) begin
            out_column_next = out_column + 1'b1;
            state_next      = SEQ_FIRST;
          end else begin
            out_column_next = '0;
            if (second_pass) begin
              second_pass_next = 1'b0;
              if (HW'(out_row) < (h >> 1) - 1'b1) begin
                out_row_next = out_row + 1'b1;
                state_next   = SEQ_FIRST;
              end else begin
                out_row_next = '0;
                state_next   = SEQ_WAIT;
              end
            end else begin
              second_pass_next = 1'b1;
              state_next       = SEQ_FIRST;
            end
          end
        end
        default: state_next = SEQ_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      in_column   <= '0;
      in_row      <= '0;
      out_column  <= '0;
      out_row     <= '0;
      second_pass <= 1'b0;
      state       <= SEQ_WAIT;
      held_mark   <= 1'b0;
    end else if (accept) begin
      armed       <= armed_next;
      in_column   <= in_column_next;
      in_row      <= in_row_next;
      out_column  <= out_column_next;
      out_row     <= out_row_next;
      second_pass <= second_pass_next;
      state       <= state_next;
      held_mark   <= held_mark_next;
    end
  end

  // command: mark, read addr, read enable, write data, write addr, write enable
  assign cmd = {held_mark_next, rd_addr, rd_en, pixel_value, wr_addr, wr_en};

endmodule

`default_nettype wire

// ===== hw/rtl/ccz_back.sv =====
// ccz_back: frame store with clearing pass, read stage and output register
// executes commands from ccz_queue; depends on ccz_pkg
`timescale 1ns / 1ps
`default_nettype none

module ccz_back #(
  parameter int PIXEL_BITS = 8,
  parameter int AW         = 16,
  parameter int EW         = 3 + 2 * 16 + 8,
  parameter int DW         = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire logic [EW-1:0] q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [DW-1:0]      m_tdata,
  output logic [1:0]         m_tuser
);
  import ccz_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [PIXEL_BITS-1:0] store [DEPTH];
  logic [AW:0]           clr_cnt;

  logic                  c_we;
  logic [AW-1:0]         c_waddr;
  logic [PIXEL_BITS-1:0] c_wdata;
  logic                  c_re;
  logic [AW-1:0]         c_raddr;
  logic                  c_mark;

  logic                  s1_valid;
  logic                  s1_re;
  logic                  s1_mark;
  logic                  s1_fwd;
  logic [PIXEL_BITS-1:0] s1_fwd_data;
  logic [PIXEL_BITS-1:0] s1_rdata;
  logic                  s2_ready;
  logic                  s1_adv;
  logic [PIXEL_BITS-1:0] held_pixel;
  logic                  line_valid;
  logic                  frame_mark;

  assign {c_mark, c_raddr, c_re, c_wdata, c_waddr, c_we} = q_data;

  assign clearing = !clr_cnt[AW];
  assign s2_ready = !m_tvalid || m_tready;
  assign s1_adv   = !s1_valid || s2_ready;
  assign q_pop    = q_valid && s1_adv && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      store[clr_cnt[AW-1:0]] <= '0;
    end else if (q_pop && c_we) begin
      store[c_waddr] <= c_wdata;
    end
    if (q_pop) begin
      s1_rdata <= store[c_raddr];
    end
  end

  // read after write within one beat takes the new pixel
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_re       <= c_re;
      s1_mark     <= c_mark;
      s1_fwd      <= c_we && (c_waddr == c_raddr);
      s1_fwd_data <= c_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      held_pixel <= '0;
      line_valid <= 1'b0;
      frame_mark <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= q_pop;
      end
      if (s1_valid && s2_ready) begin
        m_tvalid   <= 1'b1;
        line_valid <= s1_re;
        frame_mark <= s1_mark;
        if (s1_re) begin
          held_pixel <= s1_fwd ? s1_fwd_data : s1_rdata;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = DW'(held_pixel);
  assign m_tuser = {frame_mark, line_valid};

  a_clear_blocks_pop: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("store command taken during clearing pass");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (clearing && !m_tvalid && !s1_valid))
    else $error("back end not idle after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/center_crop_zoom_2x_unit.sv =====
// center_crop_zoom_2x_unit: crops the central window and zooms it 2x
// an input beat passes ccz_queue, then the read stage and output register of ccz_back;
// one beat per cycle sustained while m_tready is high, one store command per beat
// after rst the frame store is cleared, one entry a cycle, through all
// 2**(log2(MAX_WIDTH/2)+log2(MAX_HEIGHT/2)) entries (65536 at default) with s_tready low
// instantiates ccz_front, ccz_queue, ccz_back; depends on ccz_pkg
`timescale 1ns / 1ps
`default_nettype none

module center_crop_zoom_2x_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [ccz_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ccz_pkg::CFG_BITS-1:0]       cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // pixel_value
  input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]    s_tdata,
  // clear_n, frame_start, pixel_valid
  input  wire logic [2:0]                         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // pixel_result
  output logic [((PIXEL_BITS+7)/8)*8-1:0]         m_tdata,
  // line_valid, frame_mark
  output logic [1:0]                              m_tuser
);
  import ccz_pkg::*;

  localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int AW = $clog2(MAX_WIDTH / 2) + $clog2(MAX_HEIGHT / 2);
  localparam int EW = 3 + 2 * AW + PIXEL_BITS;

  logic          accept;
  logic [EW-1:0] cmd;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [EW-1:0] q_data;
  logic          clearing;

  assign s_tready = !q_full && !clearing;
  assign accept   = s_tvalid && s_tready;

  ccz_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW),
    .EW         (EW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .clear_n     (s_tuser[0]),
    .frame_start (s_tuser[1]),
    .pixel_valid (s_tuser[2]),
    .pixel_value (s_tdata[PIXEL_BITS-1:0]),
    .cmd         (cmd)
  );

  ccz_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  ccz_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .AW         (AW),
    .EW         (EW),
    .DW         (DW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_no_input_while_clearing: assert property (@(posedge clk)
    clearing |-> !s_tready)
    else $error("input beat accepted during clearing pass");

endmodule

`default_nettype wire
